>>> design/ofb_pkg.sv
// Shared codes and types for the overlap feather blend block.
package ofb_pkg;

  // Input item kinds
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_MEASURE = 2'd1;
  localparam logic [1:0] MODE_BLEND   = 2'd2;

  // Blend mode register codes (any other code selects the feather)
  localparam logic [1:0] BLEND_MAX = 2'd0;
  localparam logic [1:0] BLEND_AVG = 2'd1;

  // Configuration register indexes
  localparam logic CFG_BACKGROUND = 1'b0;
  localparam logic CFG_BLEND_MODE = 1'b1;

  // Back-end sequencer states
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DIVN  = 11'b000_0000_0010,
    S_DIVM  = 11'b000_0000_0100,
    S_RAMP  = 11'b000_0000_1000,
    S_MULA  = 11'b000_0001_0000,
    S_SQRTA = 11'b000_0010_0000,
    S_MULB  = 11'b000_0100_0000,
    S_SQRTB = 11'b000_1000_0000,
    S_MIX   = 11'b001_0000_0000,
    S_SUM   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } back_state_e;

endpackage

>>> design/ofb_fifo.sv
// Two-entry job queue between the front end and the back end.
module ofb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> design/ofb_front.sv
// Front end: accepts items, keeps the overlap range statistics, classifies blends.
module ofb_front #(
  parameter int PIXEL_BITS = 16,
  parameter int DIST_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic signed [PIXEL_BITS-1:0] new_value_i,
  input  logic [DIST_BITS-1:0]         new_distance_i,
  input  logic signed [PIXEL_BITS-1:0] merged_value_i,
  input  logic [DIST_BITS-1:0]         merged_distance_i,
  input  logic signed [PIXEL_BITS-1:0] background_i,
  input  logic [1:0]                   blend_mode_i,
  output logic                         job_push_o,
  output logic [2*PIXEL_BITS+4*(DIST_BITS+1):0] job_o,
  input  logic                         job_full_i
);

  localparam int DW = DIST_BITS + 1;

  logic [DIST_BITS-1:0] nmin_q, nmax_q, mmin_q, mmax_q;
  logic [DIST_BITS-1:0] nmin_d, nmax_d, mmin_d, mmax_d;
  logic                 first_q, first_d;
  logic                 accept, both_valid, weighted;
  logic signed [PIXEL_BITS-1:0] simple_res;
  logic signed [PIXEL_BITS:0]   avg_sum;
  logic signed [DW-1:0] dn, rn, dm, rm;

  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign both_valid = (new_value_i != background_i) && (merged_value_i != background_i);

  always_comb begin
    nmin_d  = nmin_q;
    nmax_d  = nmax_q;
    mmin_d  = mmin_q;
    mmax_d  = mmax_q;
    first_d = first_q;
    if (accept) begin
      case (mode_i)
        ofb_pkg::MODE_CLEAR: begin
          nmin_d  = '0;
          nmax_d  = '0;
          mmin_d  = '0;
          mmax_d  = '0;
          first_d = 1'b1;
        end
        ofb_pkg::MODE_MEASURE: begin
          if (both_valid) begin
            if (first_q) begin
              nmin_d = new_distance_i;
              mmin_d = merged_distance_i;
            end
            first_d = 1'b0;
            if (new_distance_i > nmax_q)    nmax_d = new_distance_i;
            if (new_distance_i < nmin_d)    nmin_d = new_distance_i;
            if (merged_distance_i > mmax_q) mmax_d = merged_distance_i;
            if (merged_distance_i < mmin_d) mmin_d = merged_distance_i;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nmin_q  <= '0;
      nmax_q  <= '0;
      mmin_q  <= '0;
      mmax_q  <= '0;
      first_q <= 1'b1;
    end else begin
      nmin_q  <= nmin_d;
      nmax_q  <= nmax_d;
      mmin_q  <= mmin_d;
      mmax_q  <= mmax_d;
      first_q <= first_d;
    end
  end

  // Simple results are settled here; the feather case carries its operands
  assign avg_sum = {new_value_i[PIXEL_BITS-1], new_value_i}
                 + {merged_value_i[PIXEL_BITS-1], merged_value_i};

  always_comb begin
    simple_res = merged_value_i;
    weighted   = 1'b0;
    case (blend_mode_i)
      ofb_pkg::BLEND_MAX: begin
        if (new_value_i != background_i && new_value_i > merged_value_i)
          simple_res = new_value_i;
      end
      ofb_pkg::BLEND_AVG: begin
        if (new_value_i != background_i) begin
          if (merged_value_i == background_i) simple_res = new_value_i;
          else simple_res = avg_sum[PIXEL_BITS:1];
        end
      end
      default: begin
        if (new_value_i != background_i) begin
          if (merged_value_i == background_i) simple_res = new_value_i;
          else begin
            // Carry the new pixel in the result slot for the back end
            weighted   = 1'b1;
            simple_res = new_value_i;
          end
        end
      end
    endcase
  end

  assign dn = $signed({1'b0, new_distance_i}) - $signed({1'b0, nmin_q});
  assign rn = $signed({1'b0, nmax_q}) - $signed({1'b0, nmin_q});
  assign dm = $signed({1'b0, merged_distance_i}) - $signed({1'b0, mmin_q});
  assign rm = $signed({1'b0, mmax_q}) - $signed({1'b0, mmin_q});

  assign job_push_o = accept && (mode_i == ofb_pkg::MODE_BLEND);
  assign job_o = {weighted, simple_res, merged_value_i, dn, rn, dm, rm};

endmodule

>>> design/ofb_back.sv
// Back end: feather weights through a shared divider and square root, plus output register.
module ofb_back #(
  parameter int PIXEL_BITS       = 16,
  parameter int DIST_BITS        = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  logic [2*PIXEL_BITS+4*(DIST_BITS+1):0] job_i,
  output logic                         job_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [PIXEL_BITS-1:0] out_value_o
);

  localparam int P  = PIXEL_BITS;
  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int DW = DIST_BITS + 1;
  localparam int CW = $clog2(F + 2);
  localparam int QW = F + 3;
  localparam int AW = F + 5;
  localparam int W  = F + 1;
  localparam int XW = 2 * F + 2;
  localparam int MW = F + P + 3;
  localparam logic [F:0]     ONE     = {1'b1, {F{1'b0}}};
  localparam logic [CW-1:0]  CNT_TOP = CW'(F);

  // Job fields
  logic                 j_wt;
  logic signed [P-1:0]  j_nv, j_mv;
  logic signed [DW-1:0] j_dn, j_rn, j_dm, j_rm;
  assign {j_wt, j_nv, j_mv, j_dn, j_rn, j_dm, j_rm} = job_i;

  ofb_pkg::back_state_e state_q, state_d;

  logic signed [P-1:0]  nv_q, mv_q;
  logic signed [DW-1:0] dm_q, rm_q;
  logic [CW-1:0]        cnt_q, cnt_d;

  // Divider
  logic [DW-1:0] div_rem_q, div_rem_d, div_rng_q, div_rng_d;
  logic [F:0]    div_quo_q, div_quo_d;
  logic          div_neg_q, div_sat_q, div_zero_q;
  logic          div_ld;
  logic signed [DW-1:0] ld_diff, ld_rng;
  logic [DW-1:0] ld_mag, div_r1;
  logic          div_t;
  logic signed [QW-1:0] div_res;
  logic signed [QW-1:0] qn_q, qm_q;

  // Ramps, roots, mix
  logic signed [AW-1:0] ra, rb;
  logic [F:0]    ah_q, bh_q, r2_q, rt_m_q;
  logic [XW-1:0] sq_x_q, sq_x_d;
  logic [W+1:0]  sq_rem_q, sq_rem_d, sq_sh, sq_trial;
  logic [W-1:0]  sq_root_q, sq_root_d;
  logic          sq_ge;
  logic [F+1:0]  mix_sum;
  logic [F:0]    ratio;
  logic signed [P:0]    dv;
  logic signed [MW-1:0] prod_q, sum_all;
  logic signed [P-1:0]  res_q;

  logic                 out_valid_q;
  logic signed [P-1:0]  out_data_q;
  logic                 out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_data_q;

  assign job_pop_o = (state_q == ofb_pkg::S_IDLE) && job_valid_i && (j_wt || out_free);

  // Divider load operands and one restoring step per cycle
  assign div_ld  = (job_pop_o && j_wt) || (state_q == ofb_pkg::S_DIVN && cnt_q == '0);
  assign ld_diff = (state_q == ofb_pkg::S_IDLE) ? j_dn : dm_q;
  assign ld_rng  = (state_q == ofb_pkg::S_IDLE) ? j_rn : rm_q;
  assign ld_mag  = ld_diff[DW-1] ? DW'(-ld_diff) : ld_diff;

  assign div_t     = (div_rem_q >= div_rng_q);
  assign div_r1    = div_t ? div_rem_q - div_rng_q : div_rem_q;
  assign div_quo_d = {div_quo_q[F-1:0], div_t};

  always_comb begin
    if (div_zero_q)     div_res = '0;
    else if (div_sat_q) div_res = div_neg_q ? -QW'(ONE) : QW'({ONE, 1'b0});
    else if (div_neg_q) div_res = (div_quo_d > ONE) ? -QW'(ONE) : -QW'(div_quo_d);
    else                div_res = QW'(div_quo_d);
  end

  // Ramps and the four clamps, applied in order
  always_comb begin
    logic signed [AW-1:0] two;
    two = AW'({ONE, 1'b0});
    ra  = AW'({ONE, 1'b0} + ONE) - (({{2{qn_q[QW-1]}}, qn_q} <<< 2)
          + {{2{qn_q[QW-1]}}, qn_q});
    rb  = AW'({ONE, 1'b0} + ONE) - (({{2{qm_q[QW-1]}}, qm_q} <<< 2)
          + {{2{qm_q[QW-1]}}, qm_q});
    if (ra < 0)    begin ra = '0;  rb = two; end
    if (rb < 0)    begin ra = two; rb = '0;  end
    if (ra >= two) begin ra = two; rb = '0;  end
    if (rb >= two) begin ra = '0;  rb = two; end
  end

  // Square root, one result bit per cycle
  assign sq_sh    = {sq_rem_q[W-1:0], sq_x_q[XW-1 -: 2]};
  assign sq_trial = {sq_root_q, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  assign mix_sum = {1'b0, r2_q} + {1'b0, ONE} - {1'b0, rt_m_q};
  assign ratio   = mix_sum[F+1:1];
  assign dv      = {nv_q[P-1], nv_q} - {mv_q[P-1], mv_q};
  assign sum_all = prod_q + (MW'(mv_q) <<< F) + (MW'(1) <<< (F - 1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    div_rem_d = {div_r1[DW-2:0], 1'b0};
    div_rng_d = div_rng_q;
    sq_x_d    = sq_x_q << 2;
    sq_rem_d  = sq_ge ? sq_sh - sq_trial : sq_sh;
    sq_root_d = {sq_root_q[W-2:0], sq_ge};
    if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
    unique case (state_q)
      ofb_pkg::S_IDLE:  if (job_pop_o && j_wt) begin
        state_d = ofb_pkg::S_DIVN;
        cnt_d   = CNT_TOP;
      end
      ofb_pkg::S_DIVN:  if (cnt_q == '0) begin
        state_d = ofb_pkg::S_DIVM;
        cnt_d   = CNT_TOP;
      end
      ofb_pkg::S_DIVM:  if (cnt_q == '0) state_d = ofb_pkg::S_RAMP;
      ofb_pkg::S_RAMP:  state_d = ofb_pkg::S_MULA;
      ofb_pkg::S_MULA: begin
        state_d   = ofb_pkg::S_SQRTA;
        cnt_d     = CNT_TOP;
        sq_x_d    = XW'(ah_q * (ONE - bh_q));
        sq_rem_d  = '0;
        sq_root_d = '0;
      end
      ofb_pkg::S_SQRTA: if (cnt_q == '0) state_d = ofb_pkg::S_MULB;
      ofb_pkg::S_MULB: begin
        state_d   = ofb_pkg::S_SQRTB;
        cnt_d     = CNT_TOP;
        sq_x_d    = XW'(bh_q * (ONE - ah_q));
        sq_rem_d  = '0;
        sq_root_d = '0;
      end
      ofb_pkg::S_SQRTB: if (cnt_q == '0) state_d = ofb_pkg::S_MIX;
      ofb_pkg::S_MIX:   state_d = ofb_pkg::S_SUM;
      ofb_pkg::S_SUM:   state_d = ofb_pkg::S_OUT;
      ofb_pkg::S_OUT:   if (out_free) state_d = ofb_pkg::S_IDLE;
      default:          state_d = ofb_pkg::S_IDLE;
    endcase
    if (div_ld) begin
      div_rem_d = ld_mag;
      div_rng_d = ld_rng;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ofb_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if ((job_pop_o && !j_wt) || (state_q == ofb_pkg::S_OUT && out_free))
        out_valid_q <= 1'b1;
      else if (out_ready_i)
        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_rng_q <= div_rng_d;
    div_quo_q <= div_quo_d;
    sq_x_q    <= sq_x_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
    if (div_ld) begin
      div_neg_q  <= ld_diff[DW-1];
      div_zero_q <= ld_rng[DW-1] || (ld_rng == '0);
      div_sat_q  <= ({1'b0, ld_mag} >= {ld_rng, 1'b0});
    end
    if (job_pop_o) begin
      nv_q <= j_nv;
      mv_q <= j_mv;
      dm_q <= j_dm;
      rm_q <= j_rm;
      if (!j_wt) out_data_q <= j_nv;
    end
    if (state_q == ofb_pkg::S_DIVN && cnt_q == '0) qn_q <= div_res;
    if (state_q == ofb_pkg::S_DIVM && cnt_q == '0) qm_q <= div_res;
    if (state_q == ofb_pkg::S_RAMP) begin
      ah_q <= ra[F+1:1];
      bh_q <= rb[F+1:1];
    end
    if (state_q == ofb_pkg::S_SQRTA && cnt_q == '0) r2_q   <= sq_root_d;
    if (state_q == ofb_pkg::S_SQRTB && cnt_q == '0) rt_m_q <= sq_root_d;
    if (state_q == ofb_pkg::S_MIX) prod_q <= $signed({1'b0, ratio}) * dv;
    if (state_q == ofb_pkg::S_SUM) res_q <= sum_all[F+P-1:F];
    if (state_q == ofb_pkg::S_OUT && out_free) out_data_q <= res_q;
  end

  // Halved ramps stay within one after the clamps
  a_ramp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ofb_pkg::S_SQRTA) |-> (ah_q <= ONE && bh_q <= ONE))
    else $error("feather ramp out of range");

  // First root never exceeds one
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ofb_pkg::S_MULB) |-> (r2_q <= ONE))
    else $error("square root out of range");

  // Mix ratio is a weight in [0, 1]
  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ofb_pkg::S_MIX) |-> (ratio <= ONE))
    else $error("mix ratio out of range");

endmodule

>>> design/overlap_feather_blend.sv
// Overlap feather blend: top level with configuration registers, front, queue and back.
//
// Usage: items enter on the s_axis channel (tdata: mode, new_value,
// new_distance, merged_value, merged_distance). Clear and measure items
// update the overlap range statistics in the front end in the cycle of the
// transfer and give no result. Blend items are placed in a two-entry queue
// and give one result on m_axis. Maximum, average and background cases
// leave the back end straight through the output register; a feather
// blend runs the shared restoring divider twice and the bit-serial square
// root twice, one feather item at a time.
// The cfg channel writes background_value (index 0) and blend_mode
// (index 1); it is always ready and must only be used while the block is
// idle. Reset clears statistics, registers and the queue. When the receiver
// stalls, the result stays in the output register, the back end holds, and
// s_axis_tready drops once the queue is full.
module overlap_feather_blend #(
  parameter int PIXEL_BITS       = 16,
  parameter int DIST_BITS        = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mode, new_value, new_distance, merged_value, merged_distance (low bit up)
  input  logic [((2+2*PIXEL_BITS+2*DIST_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // blended_value
  output logic [((PIXEL_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_addr_i,
  input  logic [PIXEL_BITS-1:0]  cfg_data_i
);

  localparam int P     = PIXEL_BITS;
  localparam int D     = DIST_BITS;
  localparam int JW    = 2 * P + 4 * (D + 1) + 1;
  localparam int OUT_W = ((P + 7) / 8) * 8;

  logic signed [P-1:0] bg_q;
  logic [1:0]          bmode_q;
  logic                job_push, job_full, job_pop, job_valid;
  logic [JW-1:0]       job_in, job_out;
  logic signed [P-1:0] out_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q    <= '0;
      bmode_q <= ofb_pkg::BLEND_MAX;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        ofb_pkg::CFG_BACKGROUND: bg_q    <= cfg_data_i;
        ofb_pkg::CFG_BLEND_MODE: bmode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ofb_front #(
    .PIXEL_BITS(P),
    .DIST_BITS (D)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .mode_i           (s_axis_tdata[1:0]),
    .new_value_i      (s_axis_tdata[2 +: P]),
    .new_distance_i   (s_axis_tdata[2+P +: D]),
    .merged_value_i   (s_axis_tdata[2+P+D +: P]),
    .merged_distance_i(s_axis_tdata[2+2*P+D +: D]),
    .background_i     (bg_q),
    .blend_mode_i     (bmode_q),
    .job_push_o       (job_push),
    .job_o            (job_in),
    .job_full_i       (job_full)
  );

  ofb_fifo #(
    .WIDTH(JW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (job_out)
  );

  ofb_back #(
    .PIXEL_BITS      (P),
    .DIST_BITS       (D),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(out_value)
  );

  assign m_axis_tdata = OUT_W'($unsigned(out_value));

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the overlap feather blend block.
module testbench;

  localparam int PB = 16;
  localparam int DB = 24;
  localparam int FB = 16;
  localparam int TDW = ((2+2*PB+2*DB+7)/8)*8;
  localparam longint ONE = 64'sd1 << FB;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  class blend_scoreboard;
    longint bg;
    logic [1:0] bmode;
    longint nmin, nmax, mmin, mmax;
    bit first;
    logic [PB-1:0] pending[$];
    int errors;

    function void reset_state();
      bg = 0; bmode = ofb_pkg::BLEND_MAX;
      nmin = 0; nmax = 0; mmin = 0; mmax = 0; first = 1;
      pending.delete(); errors = 0;
    endfunction

    function longint ramp(longint d, longint lo, longint hi);
      longint span, q;
      span = hi - lo; q = 0;
      if (span > 0) begin
        q = ((d - lo) * ONE) / span;
        if (q < -ONE) q = -ONE;
        if (q > 2*ONE) q = 2*ONE;
      end
      return 3*ONE - 5*q;
    endfunction

    function longint root(longint x);
      longint r;
      r = 0;
      while ((r+1)*(r+1) <= x) r++;
      return r;
    endfunction

    function longint fdiv(longint a, longint b);
      if (a >= 0) return a / b;
      return -((-a + b - 1) / b);
    endfunction

    function longint feather(longint nv, longint nd, longint mv, longint md);
      longint a, b, r2, rm, ratio;
      a = ramp(nd, nmin, nmax);
      b = ramp(md, mmin, mmax);
      if (a < 0) begin a = 0; b = 2*ONE; end
      if (b < 0) begin a = 2*ONE; b = 0; end
      if (a >= 2*ONE) begin a = 2*ONE; b = 0; end
      if (b >= 2*ONE) begin a = 0; b = 2*ONE; end
      a = a >>> 1; b = b >>> 1;
      r2 = root(a * (ONE - b));
      rm = root(b * (ONE - a));
      ratio = (r2 + ONE - rm) >>> 1;
      return fdiv(ratio*nv + (ONE-ratio)*mv + ONE/2, ONE);
    endfunction

    function void note_item(logic [1:0] kind, logic signed [PB-1:0] nvs, logic [DB-1:0] nd,
                            logic signed [PB-1:0] mvs, logic [DB-1:0] md);
      longint nv, mv, res;
      nv = nvs; mv = mvs; res = mv;
      case (kind)
        ofb_pkg::MODE_CLEAR: begin
          nmin = 0; nmax = 0; mmin = 0; mmax = 0; first = 1;
        end
        ofb_pkg::MODE_MEASURE: begin
          if (nv != bg && mv != bg) begin
            if (first) begin nmin = nd; mmin = md; first = 0; end
            if (nd > nmax) nmax = nd;
            if (nd < nmin) nmin = nd;
            if (md > mmax) mmax = md;
            if (md < mmin) mmin = md;
          end
        end
        ofb_pkg::MODE_BLEND: begin
          if (bmode == ofb_pkg::BLEND_MAX) begin
            if (nv != bg && nv > mv) res = nv;
          end else if (nv != bg) begin
            if (mv == bg) res = nv;
            else if (bmode == ofb_pkg::BLEND_AVG) res = fdiv(nv + mv, 2);
            else res = feather(nv, nd, mv, md);
          end
          pending.push_back(res[PB-1:0]);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [PB-1:0] got);
      logic [PB-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result expected=none actual=%h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: blended_value mismatch expected=%h actual=%h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [TDW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid_i = 0, cfg_ready_o, cfg_addr_i = 0;
  logic [PB-1:0] cfg_data_i = '0;

  blend_scoreboard sb;
  bit quiet_tail = 0;
  bit sink_enable = 0;

  overlap_feather_blend dut (.*);

  initial forever #5 clk_i = ~clk_i;

  task automatic write_reg(logic idx, logic [PB-1:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    cfg_valid_i <= 1; cfg_addr_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ofb_pkg::CFG_BACKGROUND) sb.bg = longint'($signed(val));
    else sb.bmode = val[1:0];
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Drop the input valid after the last transfer
  task automatic stop_input();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_item(logic [1:0] kind, logic [PB-1:0] nv, logic [DB-1:0] nd,
                           logic [PB-1:0] mv, logic [DB-1:0] md);
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, md, mv, nd, nv, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, nv, nd, mv, md);
  endtask

  // Random sink stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_enable && !quiet_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[PB-1:0]);

  task automatic random_value(output logic [PB-1:0] v);
    case ($urandom_range(0, 5))
      0: v = sb.bg[PB-1:0];
      1: v = 16'h8000;
      2: v = 16'h7fff;
      default: v = PB'($urandom);
    endcase
  endtask

  task automatic random_phase(int count, int dmax);
    logic [PB-1:0] nv, mv;
    logic [DB-1:0] nd, md;
    int r;
    send_item(ofb_pkg::MODE_CLEAR, PB'($urandom), DB'($urandom), PB'($urandom),
              DB'($urandom));
    for (int i = 0; i < count; i++) begin
      random_value(nv); random_value(mv);
      nd = DB'($urandom_range(0, dmax)); md = DB'($urandom_range(0, dmax));
      if ($urandom_range(0, 9) == 0) begin nd = DB'($urandom); md = DB'($urandom); end
      r = $urandom_range(0, 99);
      if (r < 2) send_item(ofb_pkg::MODE_CLEAR, nv, nd, mv, md);
      else if (r < 4) send_item(MODE_IGNORED, nv, nd, mv, md);
      else if (r < 10 + (i < count/3 ? 50 : 0)) send_item(ofb_pkg::MODE_MEASURE, nv, nd, mv, md);
      else send_item(ofb_pkg::MODE_BLEND, nv, nd, mv, md);
    end
  endtask

  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    sink_enable = 1;

    // Directed: all modes, extremes, zero range, ignored kind
    for (int bm = 0; bm < 4; bm++) begin
      write_reg(ofb_pkg::CFG_BLEND_MODE, PB'(bm));
      send_item(ofb_pkg::MODE_BLEND, 16'h7fff, 24'd0, 16'h8000, 24'hffffff);
      send_item(ofb_pkg::MODE_BLEND, 16'h8000, 24'hffffff, 16'h7fff, 24'd0);
      send_item(ofb_pkg::MODE_BLEND, 16'd0, 24'd5, 16'h1234, 24'd9);
      send_item(ofb_pkg::MODE_BLEND, 16'hfff3, 24'd5, 16'd0, 24'd9);
      send_item(ofb_pkg::MODE_BLEND, 16'hfff3, 24'd5, 16'hfffe, 24'd9);
      drain();
    end
    send_item(ofb_pkg::MODE_MEASURE, 16'd100, 24'h000100, 16'd200, 24'h000800);
    send_item(ofb_pkg::MODE_MEASURE, 16'd0, 24'hffffff, 16'd200, 24'hffffff);
    send_item(ofb_pkg::MODE_MEASURE, 16'd100, 24'hffffff, 16'd200, 24'h000000);
    send_item(MODE_IGNORED, 16'd5, 24'd7, 16'd9, 24'd11);
    send_item(ofb_pkg::MODE_BLEND, 16'h7fff, 24'h000200, 16'h8000, 24'h000400);
    send_item(ofb_pkg::MODE_BLEND, 16'h8000, 24'hffffff, 16'h7fff, 24'd0);
    drain();

    write_reg(ofb_pkg::CFG_BACKGROUND, 16'h8000);
    write_reg(ofb_pkg::CFG_BLEND_MODE, 16'd2);
    random_phase(350, 4000);
    drain();
    write_reg(ofb_pkg::CFG_BACKGROUND, 16'h7fff);
    write_reg(ofb_pkg::CFG_BLEND_MODE, 16'd1);
    random_phase(300, 24'hffffff);
    drain();
    write_reg(ofb_pkg::CFG_BACKGROUND, 16'h0000);
    write_reg(ofb_pkg::CFG_BLEND_MODE, 16'd0);
    random_phase(300, 1000);
    drain();
    write_reg(ofb_pkg::CFG_BACKGROUND, PB'($urandom));
    write_reg(ofb_pkg::CFG_BLEND_MODE, 16'd3);
    random_phase(250, 300);
    quiet_tail = 1;
    drain();
    write_reg(ofb_pkg::CFG_BACKGROUND, 16'h0000);
    write_reg(ofb_pkg::CFG_BLEND_MODE, 16'd2);
    random_phase(250, 60000);

    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
